/* rtl/rgba_source_over_compositor_core_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the compositor core RTL
// ---------------------------------------------------------------------------
`ifndef RGBA_SOURCE_OVER_COMPOSITOR_CORE_DEFINES_SVH
`define RGBA_SOURCE_OVER_COMPOSITOR_CORE_DEFINES_SVH

// check that a property holds on every clock edge out of reset
`define RSOC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check that a condition never occurs out of reset
`define RSOC_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

/* rtl/rsoc_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rsoc_pkg
// Types and constants of the source-over compositor.
// ---------------------------------------------------------------------------
package rsoc_pkg;

  localparam int unsigned PIXELS   = 65536;
  localparam int unsigned IDX_W    = $clog2(PIXELS);
  localparam int unsigned DIV_BITS = 8;
  // stage 0 holds the item, 1 products, 2 sums, 3..10 one quotient bit each
  localparam int unsigned NST      = 3 + DIV_BITS;
  // floor(x / 255) == (x * 0x8081) >> 23 for every 16-bit x
  localparam logic [15:0] RECIP255 = 16'h8081;

  typedef enum logic {
    OP_BLEND = 1'b0,
    OP_READ  = 1'b1
  } op_e;

  typedef struct packed {
    logic                   valid;
    op_e                    op;
    logic [IDX_W-1:0]       idx;
    logic [2:0][7:0]        src;
    logic [7:0]             sa;
    logic [31:0]            px;
    logic [15:0]            sa255;
    logic [15:0]            t;
    logic [2:0][15:0]       ss;
    logic [15:0]            ao;
    logic [2:0][23:0]       num;
    logic [2:0][7:0]        quo;
    logic [7:0]             alpha;
  } stage_t;

endpackage

/* rtl/rgba_source_over_compositor_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rgba_source_over_compositor_core
// Source-over blend of straight-alpha RGBA8 pixels into an on-chip canvas.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one item per pixel: tuser is the operation (0 blend,
//   1 read out and clear), tdata the pixel index and the source color.
//   m_axis returns one item per input item: the index and the resulting
//   pixel (blended value, or the stored value on a read).
//   Path from input accept to output valid: the accepting
//   edge starts the canvas RAM read, then come two multiply stages, eight
//   stages of the pipelined divider (one quotient bit per stage) and the
//   output register.
//   Throughput is one item per cycle when no stall holds. An item whose
//   index matches an item still in the pipeline waits until that item has
//   written the canvas back, since the single read-modify-write RAM has no
//   path to forward an unfinished result; back-to-back hits on one pixel
//   thus stall s_axis_tready.
//   After reset the canvas is cleared by a pass over all 65536 pixels, one
//   pixel per cycle, with s_axis_tready low.
//   When m_axis_tready is low with a result pending, the pipeline holds and
//   s_axis_tready drops; no item is lost.
// ---------------------------------------------------------------------------
module rgba_source_over_compositor_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // pixel_index, src_red, src_green, src_blue, src_alpha
  input  logic [0:0]  s_axis_tuser,  // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // out_index, out_red, out_green, out_blue, out_alpha
);
  import rsoc_pkg::*;
  `include "rgba_source_over_compositor_core_defines.svh"

  logic [31:0]      mem_q [PIXELS];
  logic [31:0]      rdata_q;
  logic             clearing_q;
  logic [IDX_W-1:0] clr_cnt_q;

  stage_t           pipe_q [NST];
  stage_t           nxt    [NST];
  logic             out_valid_q;
  logic [47:0]      out_data_q;

  logic             advance, hazard, accept;
  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [31:0]      wdata;
  logic             pipe_we;
  logic [31:0]      new_px, res_px;
  logic [31:0]      alpha_prod;

  stage_t           last;
  assign last = pipe_q[NST-1];

  assign advance = !out_valid_q || m_axis_tready;

  always_comb begin
    hazard = 1'b0;
    for (int i = 0; i < NST; i++) begin
      if (pipe_q[i].valid && pipe_q[i].idx == s_axis_tdata[IDX_W-1:0]) hazard = 1'b1;
    end
  end

  assign s_axis_tready = !clearing_q && advance && !hazard;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // stage logic
  always_comb begin
    logic [23:0] dvs;
    nxt[0]       = '0;
    nxt[0].valid = accept;
    nxt[0].op    = op_e'(s_axis_tuser[0]);
    nxt[0].idx   = s_axis_tdata[IDX_W-1:0];
    nxt[0].src   = s_axis_tdata[39:16];
    nxt[0].sa    = s_axis_tdata[47:40];
    alpha_prod   = 32'(pipe_q[2].ao) * 32'(RECIP255);
    for (int i = 1; i < NST; i++) begin
      nxt[i] = pipe_q[i-1];
      if (i == 1) begin
        nxt[i].px    = rdata_q;
        nxt[i].t     = 16'(rdata_q[31:24]) * 16'(8'd255 - pipe_q[0].sa);
        nxt[i].sa255 = {pipe_q[0].sa, 8'd0} - 16'(pipe_q[0].sa);
        for (int c = 0; c < 3; c++) begin
          nxt[i].ss[c] = 16'(pipe_q[0].src[c]) * 16'(pipe_q[0].sa);
        end
      end else if (i == 2) begin
        nxt[i].ao = pipe_q[1].sa255 + pipe_q[1].t;
        for (int c = 0; c < 3; c++) begin
          nxt[i].num[c] = ({pipe_q[1].ss[c], 8'd0} - 24'(pipe_q[1].ss[c]))
                        + 24'(pipe_q[1].px[8*c +: 8]) * 24'(pipe_q[1].t);
        end
      end else begin
        // restoring division, one quotient bit per stage, msb first
        dvs = 24'(pipe_q[i-1].ao) << (NST - 1 - i);
        if (i == 3) nxt[i].alpha = alpha_prod[30:23];
        for (int c = 0; c < 3; c++) begin
          if (pipe_q[i-1].num[c] >= dvs) begin
            nxt[i].num[c]               = pipe_q[i-1].num[c] - dvs;
            nxt[i].quo[c][NST - 1 - i]  = 1'b1;
          end else begin
            nxt[i].quo[c][NST - 1 - i]  = 1'b0;
          end
        end
      end
    end
  end

  // write back and result
  always_comb begin
    new_px  = {last.alpha, last.quo[2], last.quo[1], last.quo[0]};
    pipe_we = 1'b0;
    res_px  = last.px;
    wdata   = 32'd0;
    if (last.op == OP_READ) begin
      pipe_we = 1'b1;
    end else if (last.ao != 16'd0) begin
      pipe_we = 1'b1;
      res_px  = new_px;
      wdata   = new_px;
    end
    pipe_we = pipe_we && last.valid && advance;
    waddr   = last.idx;
    we      = pipe_we;
    if (clearing_q) begin
      we    = 1'b1;
      waddr = clr_cnt_q;
      wdata = 32'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (accept) rdata_q <= mem_q[s_axis_tdata[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q  <= 1'b1;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NST; i++) pipe_q[i].valid <= 1'b0;
    end else begin
      if (clearing_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == IDX_W'(PIXELS - 1)) clearing_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= last.valid;
        for (int i = 0; i < NST; i++) pipe_q[i] <= nxt[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) out_data_q <= {res_px[31:24], res_px[23:16], res_px[15:8],
                                res_px[7:0], last.idx};
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `RSOC_NEVER(a_no_accept_clearing, clearing_q && s_axis_tready, "item taken during clear pass")
  `RSOC_NEVER(a_no_pipe_wr_clearing, clearing_q && pipe_we, "pipeline write during clear pass")
  `RSOC_ASSERT(a_alpha_ge_src, (pipe_we && last.op == OP_BLEND) |-> (new_px[31:24] >= last.sa), "blended alpha below source alpha")
  `RSOC_NEVER(a_out_dup_idx, pipe_q[0].valid && pipe_q[1].valid && pipe_q[0].idx == pipe_q[1].idx, "same pixel twice in flight")

endmodule

/* tb/sv/tb_rgba_source_over_compositor_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_rgba_source_over_compositor_core
// Streams blend and read items through the compositor. A canvas model in the
// bench predicts every output pixel, and the monitor compares each result
// with the oldest prediction.
// ---------------------------------------------------------------------------
module tb_rgba_source_over_compositor_core;
  import rsoc_pkg::*;

  typedef struct packed {
    op_e         op;
    logic [15:0] idx;
    logic [7:0]  r, g, b, a;
  } pix_item_t;

  typedef struct packed {
    logic [15:0] idx;
    logic [7:0]  r, g, b, a;
  } pix_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;

  rgba_source_over_compositor_core dut (.*);

  always #1 clk_i = ~clk_i;

  pix_item_t   pending_items[$];
  pix_result_t expected_pixels[$];
  logic [31:0] canvas_model[int];
  int          err_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          recv_hold = 1'b0;
  bit          hold_req = 1'b0;
  logic [15:0] hot_idx[4];
  logic        s_axis_tready_q = 1'b0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // source-over on the canvas model; one predicted result per item
  function automatic pix_result_t composite_pixel(input pix_item_t it);
    logic [31:0] px;
    int unsigned da, ao, s[3], num;
    pix_result_t res;
    px = canvas_model.exists(it.idx) ? canvas_model[it.idx] : 32'h0;
    if (it.op == OP_READ) begin
      canvas_model[it.idx] = 32'h0;
    end else begin
      da = px[31:24];
      ao = it.a * 255 + da * (255 - it.a);
      if (ao != 0) begin
        s[0] = it.r; s[1] = it.g; s[2] = it.b;
        for (int k = 0; k < 3; k++) begin
          num = s[k] * it.a * 255 + px[8*k +: 8] * da * (255 - it.a);
          px[8*k +: 8] = 8'(num / ao);
        end
        px[31:24] = 8'(ao / 255);
        canvas_model[it.idx] = px;
      end
    end
    res.idx = it.idx;
    res.r = px[7:0]; res.g = px[15:8]; res.b = px[23:16]; res.a = px[31:24];
    return res;
  endfunction

  // driver: drop valid after accept, pick next item at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || s_axis_tready_q) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          pix_item_t it;
          it = pending_items.pop_front();
          expected_pixels.insert(expected_pixels.size(), composite_pixel(it));
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= it.op;
          s_axis_tdata  <= {it.a, it.b, it.g, it.r, it.idx};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // accept flag sampled at the rising edge
  always @(posedge clk_i) s_axis_tready_q <= s_axis_tvalid && s_axis_tready;

  // long receiver stall, counted in cycles here
  initial begin
    wait (hold_req);
    recv_hold = 1'b1;
    repeat (200) @(posedge clk_i);
    recv_hold = 1'b0;
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      pix_result_t want;
      if (expected_pixels.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata[15:0], 0);
      end else begin
        want = expected_pixels.pop_front();
        if (m_axis_tdata[15:0] != want.idx)
          report_mismatch("index", m_axis_tdata[15:0], want.idx);
        if (m_axis_tdata[23:16] != want.r) report_mismatch("red", m_axis_tdata[23:16], want.r);
        if (m_axis_tdata[31:24] != want.g)
          report_mismatch("green", m_axis_tdata[31:24], want.g);
        if (m_axis_tdata[39:32] != want.b)
          report_mismatch("blue", m_axis_tdata[39:32], want.b);
        if (m_axis_tdata[47:40] != want.a)
          report_mismatch("alpha", m_axis_tdata[47:40], want.a);
      end
    end
  end

  function automatic pix_item_t make_item(input op_e op, input logic [15:0] idx,
                                          input logic [7:0] r, g, b, a);
    pix_item_t it;
    it.op = op; it.idx = idx; it.r = r; it.g = g; it.b = b; it.a = a;
    return it;
  endfunction

  // mostly blends on a few hot pixels so canvas state builds up
  function automatic pix_item_t random_item();
    pix_item_t it;
    int sel;
    sel = $urandom_range(99);
    it.op = (sel < 15) ? OP_READ : OP_BLEND;
    it.idx = ($urandom_range(99) < 70) ? hot_idx[$urandom_range(3)] : 16'($urandom);
    it.r = 8'($urandom); it.g = 8'($urandom); it.b = 8'($urandom);
    case ($urandom_range(5))
      0:       it.a = 8'h00;
      1:       it.a = 8'hff;
      default: it.a = 8'($urandom);
    endcase
    return it;
  endfunction

  function automatic void queue_item(input pix_item_t it);
    pending_items.insert(pending_items.size(), it);
  endfunction

  task automatic wait_drained();
    while (pending_items.size() > 0 || s_axis_tvalid || expected_pixels.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    hot_idx[0] = 16'h0000; hot_idx[1] = 16'hffff; hot_idx[2] = 16'h5a5a; hot_idx[3] = 16'h0001;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // directed: zero alpha on empty pixel, opaque, half, extremes, reads
    queue_item(make_item(OP_BLEND, 16'h0000, 8'hff, 8'hff, 8'hff, 8'h00));
    queue_item(make_item(OP_BLEND, 16'h0000, 8'hff, 8'h00, 8'haa, 8'hff));
    queue_item(make_item(OP_BLEND, 16'h0000, 8'h00, 8'hff, 8'h55, 8'h80));
    queue_item(make_item(OP_BLEND, 16'h0000, 8'h12, 8'h34, 8'h56, 8'h00));
    queue_item(make_item(OP_BLEND, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h01));
    queue_item(make_item(OP_READ,  16'h0000, 8'hff, 8'hff, 8'hff, 8'hff));
    queue_item(make_item(OP_READ,  16'h0000, 8'h00, 8'h00, 8'h00, 8'h00));
    queue_item(make_item(OP_BLEND, 16'hffff, 8'hff, 8'hff, 8'hff, 8'hff));
    queue_item(make_item(OP_BLEND, 16'hffff, 8'h00, 8'h00, 8'h00, 8'hfe));
    queue_item(make_item(OP_READ,  16'hffff, 8'h00, 8'h00, 8'h00, 8'h00));
    queue_item(make_item(OP_READ,  16'h8000, 8'h5a, 8'ha5, 8'h0f, 8'hf0));
    queue_item(make_item(OP_BLEND, 16'h7fff, 8'h01, 8'h80, 8'h7f, 8'h7f));
    queue_item(make_item(OP_BLEND, 16'h7fff, 8'hfe, 8'h01, 8'hff, 8'h01));
    queue_item(make_item(OP_READ,  16'h7fff, 8'h00, 8'h00, 8'h00, 8'h00));
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1 || ph == 3) ? 70 : 0;
      recv_stall_pct = (ph == 2) ? 70 : (ph == 3) ? 17 : 0;
      if (ph == 3) send_idle_pct = 17;
      for (int i = 0; i < 100; i++) queue_item(random_item());
      // hold off the receiver so the pipeline backs up
      if (ph == 0) hold_req = 1'b1;
      wait_drained();
    end
    send_idle_pct = 0; recv_stall_pct = 0;
    for (int i = 0; i < 36; i++) queue_item(random_item());
    wait_drained();
    repeat (30) @(posedge clk_i);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
